FILE: rtl/assert_macros.svh
// Assertion helpers included by the frame decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is switched off while reset is held.
`define ASSERT_SYNC(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Clocked check that also holds through reset.
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

FILE: rtl/slcfd_pkg.sv
package slcfd_pkg;

  localparam logic [7:0] SYNC_FIRST  = 8'hA5;
  localparam logic [7:0] SYNC_SECOND = 8'h5A;
  localparam logic [7:0] CRC8_GENERATOR = 8'h07;
  localparam logic [7:0] CRC_TOPBIT  = 8'h80;
  localparam logic [15:0] MIN_PAYLOAD = 16'd4;

  localparam logic [7:0]  ACCEPTED_COMMAND_RST = 8'h01;
  localparam logic [15:0] MAX_PAYLOAD_LEN_RST  = 16'd1024;

  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_ACCEPTED_COMMAND = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_PAYLOAD_LEN  = 2'd1;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_BADCMD  = 3'd1,
    ST_BADCRC  = 3'd2,
    ST_SHORT   = 3'd3,
    ST_TOOLONG = 3'd4
  } status_t;

  typedef enum logic [6:0] {
    PH_HUNT1   = 7'b0000001,
    PH_HUNT2   = 7'b0000010,
    PH_LENH    = 7'b0000100,
    PH_LENL    = 7'b0001000,
    PH_CMD     = 7'b0010000,
    PH_PAYLOAD = 7'b0100000,
    PH_CRC     = 7'b1000000
  } phase_t;

  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_TOPBIT) != 8'h00) begin
        c = {c[6:0], 1'b0} ^ CRC8_GENERATOR;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

FILE: rtl/sync_length_crc8_frame_decoder.sv
// Channel | Direction | Transfer content
// in_     | slave     | tdata[7:0] rx_byte
// out_    | master    | tdata command, scan_type, gain_setting, integration_time; tuser status
// cfg_    | slave     | cfg_index register number, cfg_data value
//
// One received byte is taken every cycle while in_tready is high; its parse step and CRC update complete in that cycle.
// A frame result appears in the output register the cycle after its last byte is taken.
// in_tready is low only while a result waits in the output register and out_tready is low.
// Synchronous active-low reset returns the parser to the sync hunt and empties the output.
// Configuration writes are always accepted; cfg_ready stays high.
`include "assert_macros.svh"

module sync_length_crc8_frame_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [7:0] command, [15:8] scan_type, [23:16] gain_setting,
                                  // [39:24] integration_time
  output logic [2:0]  out_tuser,  // [2:0] frame_status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [slcfd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [15:0] cfg_data
);

  logic [7:0]  acc_cmd_r;
  logic [15:0] max_len_r;

  slcfd_pkg::phase_t phase_r, phase_nxt;
  logic [15:0] decl_len_r, decl_len_nxt;
  logic [15:0] left_r, left_nxt;
  logic [7:0]  crc_r, crc_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [7:0]  gain_r, gain_nxt;
  logic [15:0] integ_r, integ_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [39:0] out_data_r, out_data_nxt;
  logic [2:0]  out_user_r, out_user_nxt;

  logic        in_fire;
  logic        res_fire;
  logic [7:0]  b;
  logic [7:0]  crc_upd;
  logic [15:0] len_full;
  logic [15:0] pos;
  logic [15:0] left_dec;
  slcfd_pkg::status_t status;

  assign in_tready  = !out_valid_r || out_tready;
  assign in_fire    = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  assign b        = in_tdata;
  assign crc_upd  = slcfd_pkg::crc8_update(crc_r, b);
  assign len_full = {decl_len_r[15:8], b};
  assign pos      = decl_len_r - left_r;
  assign left_dec = left_r - 16'd1;

  always_comb begin
    if (decl_len_r < slcfd_pkg::MIN_PAYLOAD) begin
      status = slcfd_pkg::ST_SHORT;
    end else if (cmd_r != acc_cmd_r) begin
      status = slcfd_pkg::ST_BADCMD;
    end else if (crc_r != b) begin
      status = slcfd_pkg::ST_BADCRC;
    end else begin
      status = slcfd_pkg::ST_OK;
    end
  end

  always_comb begin
    phase_nxt    = phase_r;
    decl_len_nxt = decl_len_r;
    left_nxt     = left_r;
    crc_nxt      = crc_r;
    cmd_nxt      = cmd_r;
    type_nxt     = type_r;
    gain_nxt     = gain_r;
    integ_nxt    = integ_r;
    res_fire     = 1'b0;
    out_user_nxt = out_user_r;
    out_data_nxt = out_data_r;
    if (in_fire) begin
      unique case (phase_r)
        slcfd_pkg::PH_HUNT2: begin
          if (b == slcfd_pkg::SYNC_SECOND) begin
            phase_nxt = slcfd_pkg::PH_LENH;
          end else if (b != slcfd_pkg::SYNC_FIRST) begin
            phase_nxt = slcfd_pkg::PH_HUNT1;
          end
        end
        slcfd_pkg::PH_LENH: begin
          decl_len_nxt = {b, 8'h00};
          phase_nxt    = slcfd_pkg::PH_LENL;
        end
        slcfd_pkg::PH_LENL: begin
          decl_len_nxt = len_full;
          if (len_full > max_len_r) begin
            phase_nxt    = slcfd_pkg::PH_HUNT1;
            res_fire     = 1'b1;
            out_user_nxt = slcfd_pkg::ST_TOOLONG;
            out_data_nxt = '0;
          end else begin
            left_nxt  = len_full;
            phase_nxt = slcfd_pkg::PH_CMD;
          end
        end
        slcfd_pkg::PH_CMD: begin
          cmd_nxt   = b;
          crc_nxt   = slcfd_pkg::crc8_update(8'h00, b);
          type_nxt  = 8'h00;
          gain_nxt  = 8'h00;
          integ_nxt = 16'h0000;
          phase_nxt = (left_r == 16'd0) ? slcfd_pkg::PH_CRC : slcfd_pkg::PH_PAYLOAD;
        end
        slcfd_pkg::PH_PAYLOAD: begin
          crc_nxt = crc_upd;
          if (pos[15:2] == 14'd0) begin
            case (pos[1:0])
              2'd0:    type_nxt = b;
              2'd1:    gain_nxt = b;
              2'd2:    integ_nxt = {b, integ_r[7:0]};
              default: integ_nxt = {integ_r[15:8], b};
            endcase
          end
          left_nxt = left_dec;
          if (left_dec == 16'd0) begin
            phase_nxt = slcfd_pkg::PH_CRC;
          end
        end
        slcfd_pkg::PH_CRC: begin
          phase_nxt    = slcfd_pkg::PH_HUNT1;
          res_fire     = 1'b1;
          out_user_nxt = status;
          out_data_nxt = {integ_r, gain_r, type_r, cmd_r};
        end
        default: begin
          phase_nxt = (b == slcfd_pkg::SYNC_FIRST) ? slcfd_pkg::PH_HUNT2 : slcfd_pkg::PH_HUNT1;
        end
      endcase
    end
    if (res_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_cmd_r   <= slcfd_pkg::ACCEPTED_COMMAND_RST;
      max_len_r   <= slcfd_pkg::MAX_PAYLOAD_LEN_RST;
      phase_r     <= slcfd_pkg::PH_HUNT1;
      decl_len_r  <= 16'h0000;
      left_r      <= 16'h0000;
      crc_r       <= 8'h00;
      cmd_r       <= 8'h00;
      type_r      <= 8'h00;
      gain_r      <= 8'h00;
      integ_r     <= 16'h0000;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == slcfd_pkg::CFG_ACCEPTED_COMMAND) begin
          acc_cmd_r <= cfg_data[7:0];
        end else if (cfg_index == slcfd_pkg::CFG_MAX_PAYLOAD_LEN) begin
          max_len_r <= cfg_data;
        end
      end
      phase_r     <= phase_nxt;
      decl_len_r  <= decl_len_nxt;
      left_r      <= left_nxt;
      crc_r       <= crc_nxt;
      cmd_r       <= cmd_nxt;
      type_r      <= type_nxt;
      gain_r      <= gain_nxt;
      integ_r     <= integ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  `ASSERT_SYNC(a_crc_gives_result, clk, rst_n,
    in_fire && phase_r == slcfd_pkg::PH_CRC |=> out_tvalid && out_tuser != slcfd_pkg::ST_TOOLONG)
  `ASSERT_SYNC(a_no_overwrite, clk, rst_n, out_tvalid && !out_tready |-> !in_tready)
  `ASSERT_SYNC(a_toolong_zero, clk, rst_n,
    out_tvalid && out_tuser == slcfd_pkg::ST_TOOLONG |-> out_tdata == 40'd0)
  `ASSERT_SYNC(a_hunt_stays_hunt, clk, rst_n,
    in_fire && phase_r == slcfd_pkg::PH_HUNT1 |=>
      phase_r == slcfd_pkg::PH_HUNT1 || phase_r == slcfd_pkg::PH_HUNT2)
  `ASSERT_ALWAYS(a_reset_empties, clk, !rst_n |=> !out_tvalid)

endmodule

FILE: dv/tb_sync_length_crc8_frame_decoder.sv
module tb_sync_length_crc8_frame_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_WAIT      = 13;
  localparam int SETTLE_CYCLES = 4;
  localparam int RANDOM_BYTES  = 220;
  localparam int NO_FILL       = -1;
  localparam logic [15:0] LONG_LIMIT = 16'd40;

  typedef struct packed {
    slcfd_pkg::status_t status;
    logic [7:0]  command;
    logic [7:0]  scan_type;
    logic [7:0]  gain_setting;
    logic [15:0] integration_time;
  } frame_result_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [slcfd_pkg::CFG_INDEX_W-1:0] cfg_index = slcfd_pkg::CFG_ACCEPTED_COMMAND;
  logic [15:0] cfg_data   = 16'h0000;

  sync_length_crc8_frame_decoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #6 clk = ~clk;

  // Decoder state as seen from the byte stream.
  slcfd_pkg::phase_t parse_ph = slcfd_pkg::PH_HUNT1;
  logic [15:0] frame_len  = 16'h0000;
  logic [15:0] remaining  = 16'h0000;
  logic [7:0]  crc_acc    = 8'h00;
  logic [7:0]  frame_cmd  = 8'h00;
  logic [7:0]  cap_type   = 8'h00;
  logic [7:0]  cap_gain   = 8'h00;
  logic [15:0] cap_integ  = 16'h0000;
  logic [7:0]  want_cmd   = slcfd_pkg::ACCEPTED_COMMAND_RST;
  logic [15:0] len_limit  = slcfd_pkg::MAX_PAYLOAD_LEN_RST;

  frame_result_t pending_frames[$];

  int errors         = 0;
  int bytes_sent     = 0;
  int frames_checked = 0;
  int reg_writes     = 0;
  int in_burst       = 0;
  int out_burst      = 0;
  int out_hold       = 0;

  function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] r;
    logic       fb;
    r = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      fb = r[7];
      r  = r << 1;
      if (fb) begin
        r = r ^ slcfd_pkg::CRC8_GENERATOR;
      end
    end
    return r;
  endfunction

  function automatic int draw_wait(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      burst = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, MAX_WAIT);
  endfunction

  function automatic void decode_byte(input logic [7:0] b);
    frame_result_t r;
    logic [15:0]   pos;
    r = '0;
    case (parse_ph)
      slcfd_pkg::PH_HUNT2: begin
        if (b == slcfd_pkg::SYNC_SECOND) begin
          parse_ph = slcfd_pkg::PH_LENH;
        end else if (b != slcfd_pkg::SYNC_FIRST) begin
          parse_ph = slcfd_pkg::PH_HUNT1;
        end
      end
      slcfd_pkg::PH_LENH: begin
        frame_len = {b, 8'h00};
        parse_ph  = slcfd_pkg::PH_LENL;
      end
      slcfd_pkg::PH_LENL: begin
        frame_len[7:0] = b;
        if (frame_len > len_limit) begin
          r.status = slcfd_pkg::ST_TOOLONG;
          pending_frames.push_back(r);
          parse_ph = slcfd_pkg::PH_HUNT1;
        end else begin
          remaining = frame_len;
          parse_ph  = slcfd_pkg::PH_CMD;
        end
      end
      slcfd_pkg::PH_CMD: begin
        frame_cmd = b;
        crc_acc   = crc8_next(8'h00, b);
        cap_type  = 8'h00;
        cap_gain  = 8'h00;
        cap_integ = 16'h0000;
        parse_ph  = (remaining == 16'd0) ? slcfd_pkg::PH_CRC : slcfd_pkg::PH_PAYLOAD;
      end
      slcfd_pkg::PH_PAYLOAD: begin
        crc_acc = crc8_next(crc_acc, b);
        pos     = frame_len - remaining;
        case (pos)
          16'd0: cap_type = b;
          16'd1: cap_gain = b;
          16'd2: cap_integ[15:8] = b;
          16'd3: cap_integ[7:0] = b;
          default: ;
        endcase
        remaining = remaining - 16'd1;
        if (remaining == 16'd0) begin
          parse_ph = slcfd_pkg::PH_CRC;
        end
      end
      slcfd_pkg::PH_CRC: begin
        if (frame_len < slcfd_pkg::MIN_PAYLOAD) begin
          r.status = slcfd_pkg::ST_SHORT;
        end else if (frame_cmd != want_cmd) begin
          r.status = slcfd_pkg::ST_BADCMD;
        end else if (crc_acc != b) begin
          r.status = slcfd_pkg::ST_BADCRC;
        end else begin
          r.status = slcfd_pkg::ST_OK;
        end
        r.command          = frame_cmd;
        r.scan_type        = cap_type;
        r.gain_setting     = cap_gain;
        r.integration_time = cap_integ;
        pending_frames.push_back(r);
        parse_ph = slcfd_pkg::PH_HUNT1;
      end
      default: begin
        parse_ph = (b == slcfd_pkg::SYNC_FIRST) ? slcfd_pkg::PH_HUNT2 : slcfd_pkg::PH_HUNT1;
      end
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endfunction

  // Result side: every transfer is matched against the oldest decoded frame.
  always @(posedge clk) begin : check_results
    frame_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_frames.size() == 0) begin
        $error("frame result with status %0d arrived with no frame pending", out_tuser);
        errors++;
      end else begin
        want = pending_frames.pop_front();
        check_field("frame_status", 16'(want.status), 16'(out_tuser));
        check_field("command", 16'(want.command), 16'(out_tdata[7:0]));
        check_field("scan_type", 16'(want.scan_type), 16'(out_tdata[15:8]));
        check_field("gain_setting", 16'(want.gain_setting), 16'(out_tdata[23:16]));
        check_field("integration_time", want.integration_time, out_tdata[39:24]);
        frames_checked++;
      end
      out_hold = draw_wait(out_burst);
    end
    if (out_hold > 0) begin
      out_tready <= 1'b0;
      out_hold--;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = draw_wait(in_burst);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    decode_byte(b);
    bytes_sent++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [slcfd_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [15:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == slcfd_pkg::CFG_ACCEPTED_COMMAND) begin
      want_cmd = value[7:0];
    end else if (idx == slcfd_pkg::CFG_MAX_PAYLOAD_LEN) begin
      len_limit = value;
    end
    reg_writes++;
  endtask

  // The upper half of the data word is ignored for the command register.
  task automatic set_command(input logic [7:0] cmd);
    logic [7:0] junk;
    junk = 8'($urandom_range(0, 255));
    write_reg(slcfd_pkg::CFG_ACCEPTED_COMMAND, {junk, cmd});
  endtask

  task automatic send_frame(input logic [7:0] cmd, input int len, input bit corrupt_crc,
                            input int extra_sync, input int fill);
    logic [7:0]  crc;
    logic [7:0]  b;
    logic [15:0] len16;
    len16 = len[15:0];
    repeat (extra_sync) send_byte(slcfd_pkg::SYNC_FIRST);
    send_byte(slcfd_pkg::SYNC_FIRST);
    send_byte(slcfd_pkg::SYNC_SECOND);
    send_byte(len16[15:8]);
    send_byte(len16[7:0]);
    if (len16 <= len_limit) begin
      send_byte(cmd);
      crc = crc8_next(8'h00, cmd);
      for (int i = 0; i < len; i++) begin
        b = (fill < 0) ? 8'($urandom_range(0, 255)) : fill[7:0];
        send_byte(b);
        crc = crc8_next(crc, b);
      end
      if (corrupt_crc) begin
        crc = crc ^ 8'($urandom_range(1, 255));
      end
      send_byte(crc);
    end
  endtask

  task automatic test_sync_hunt();
    send_byte(8'h00);
    send_byte(slcfd_pkg::SYNC_FIRST);
    send_byte(8'h33);
    send_frame(want_cmd, 4, 1'b0, 2, 8'hFF);
  endtask

  task automatic test_status_priority();
    send_frame(~want_cmd, 2, 1'b1, 0, NO_FILL);
    send_frame(~want_cmd, 4, 1'b1, 0, NO_FILL);
    send_frame(want_cmd, 4, 1'b1, 0, 8'h00);
  endtask

  task automatic test_zero_and_short();
    send_frame(want_cmd, 0, 1'b0, 0, NO_FILL);
    send_frame(want_cmd, 3, 1'b0, 0, NO_FILL);
  endtask

  task automatic test_length_limit();
    write_reg(slcfd_pkg::CFG_MAX_PAYLOAD_LEN, 16'd4);
    send_frame(want_cmd, 65535, 1'b0, 0, NO_FILL);
    send_frame(want_cmd, 5, 1'b0, 0, NO_FILL);
    send_frame(want_cmd, 4, 1'b0, 0, NO_FILL);
    // With a limit below the minimum, short frames within it still report as short.
    write_reg(slcfd_pkg::CFG_MAX_PAYLOAD_LEN, 16'd2);
    send_frame(want_cmd, 2, 1'b0, 0, NO_FILL);
    send_frame(want_cmd, 3, 1'b0, 0, NO_FILL);
    write_reg(slcfd_pkg::CFG_MAX_PAYLOAD_LEN, 16'hFFFF);
    send_frame(want_cmd, 9, 1'b0, 0, NO_FILL);
    write_reg(slcfd_pkg::CFG_MAX_PAYLOAD_LEN, slcfd_pkg::MAX_PAYLOAD_LEN_RST);
  endtask

  task automatic test_command_register();
    set_command(8'h00);
    send_frame(8'h00, 4, 1'b0, 0, NO_FILL);
    send_frame(8'hFF, 4, 1'b0, 0, NO_FILL);
    set_command(8'hFF);
    send_frame(8'hFF, 5, 1'b0, 0, NO_FILL);
    set_command(slcfd_pkg::ACCEPTED_COMMAND_RST);
  endtask

  task automatic test_long_frame();
    write_reg(slcfd_pkg::CFG_MAX_PAYLOAD_LEN, LONG_LIMIT);
    send_frame(want_cmd, int'(len_limit), 1'b0, 0, NO_FILL);
    send_frame(want_cmd, int'(len_limit) + 1, 1'b0, 0, NO_FILL);
    write_reg(slcfd_pkg::CFG_MAX_PAYLOAD_LEN, slcfd_pkg::MAX_PAYLOAD_LEN_RST);
  endtask

  task automatic test_random_traffic();
    int         start;
    int         kind;
    int         lim;
    int         len;
    logic [7:0] cmd;
    logic [7:0] b;
    start = bytes_sent;
    while (bytes_sent - start < RANDOM_BYTES) begin
      if ($urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 3))
          0: set_command(8'h00);
          1: set_command(8'hFF);
          default: set_command(8'($urandom_range(0, 255)));
        endcase
        case ($urandom_range(0, 5))
          0: write_reg(slcfd_pkg::CFG_MAX_PAYLOAD_LEN, 16'd4);
          1: write_reg(slcfd_pkg::CFG_MAX_PAYLOAD_LEN, 16'hFFFF);
          2: write_reg(slcfd_pkg::CFG_MAX_PAYLOAD_LEN, slcfd_pkg::MAX_PAYLOAD_LEN_RST);
          3: write_reg(slcfd_pkg::CFG_MAX_PAYLOAD_LEN, 16'($urandom_range(0, 3)));
          default: write_reg(slcfd_pkg::CFG_MAX_PAYLOAD_LEN, 16'($urandom_range(5, 64)));
        endcase
      end
      lim  = int'(len_limit);
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        // Line noise that never opens a sync pair.
        repeat ($urandom_range(1, 6)) begin
          b = 8'($urandom_range(0, 255));
          if (b == slcfd_pkg::SYNC_FIRST) begin
            b = slcfd_pkg::SYNC_SECOND;
          end
          send_byte(b);
        end
      end else if (kind == 1) begin
        send_byte(slcfd_pkg::SYNC_FIRST);
        b = 8'($urandom_range(0, 255));
        if (b == slcfd_pkg::SYNC_FIRST || b == slcfd_pkg::SYNC_SECOND) begin
          b = 8'h00;
        end
        send_byte(b);
      end else if (kind == 2 && lim < 65535) begin
        send_frame(want_cmd, $urandom_range(lim + 1, 65535), 1'b0, 0, NO_FILL);
      end else begin
        cmd = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : want_cmd;
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 48) : $urandom_range(0, 12);
        if (len > lim) begin
          len = lim;
        end
        send_frame(cmd, len, $urandom_range(0, 5) == 0,
                   ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0, NO_FILL);
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_sync_hunt();
    test_status_priority();
    test_zero_and_short();
    test_length_limit();
    test_command_register();
    test_long_frame();
    test_random_traffic();
    drain();
    $display("Decoded %0d received bytes into %0d checked frame results with %0d register writes,",
             bytes_sent, frames_checked, reg_writes);
    $display("covering sync hunting, every status, length limits and random stalls on both sides.");
    if (errors == 0) begin
      $display("PASS sync_length_crc8_frame_decoder");
    end else begin
      $display("FAIL sync_length_crc8_frame_decoder");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("FAIL sync_length_crc8_frame_decoder");
    $finish;
  end

endmodule
